### src/sblc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_pkg: shared definitions of the size-budget LRU cache
// Geometry constants, operation codes, the cell command and chain types and
// output saturation helpers.
// ----------------------------------------------------------------------------
package sblc_pkg;

   localparam int ENTRIES    = 16;
   localparam int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int TOT_RAW_W  = 24 + $clog2(ENTRIES);
   localparam int TOT_W      = (TOT_RAW_W > 28) ? TOT_RAW_W : 28;
   localparam int CMP_W      = (TOT_W > 32) ? TOT_W : 32;
   localparam logic [31:0] MAX_SIZE_RESET = 32'd8196;

   localparam logic [1:0] OP_FETCH  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_TRIM   = 2'd3;

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_MATCH,
      SEL_OLDEST,
      SEL_FREE
   } sel_mode_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_NEWEST,
      ACT_DROP,
      ACT_PLACE
   } action_type;

   typedef struct packed {
      sel_mode_type        mode;
      action_type          action;
      logic                write;
      logic [31:0]         key;
      logic [31:0]         tag;
      logic [31:0]         stamp;
      logic [23:0]         bytes;
      logic [RANK_W-1:0]   ref_rank;
      logic [RANK_W-1:0]   new_rank;
   } cmd_type;

   // Carried from cell to cell: whether a free cell was seen upstream, and
   // the fields of the selected cell, ORed in where the selection lies.
   typedef struct packed {
      logic                free_seen;
      logic                found;
      logic [RANK_W-1:0]   rank;
      logic [23:0]         bytes;
      logic [31:0]         tag;
      logic [31:0]         stamp;
   } chain_type;

   typedef struct packed {
      logic match;
      logic oldest;
   } status_type;

   function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] v);
      logic [7:0] w;
      w = 8'(v);
      return (w > 8'd31) ? 5'd31 : w[4:0];
   endfunction

   function automatic logic [27:0] sat_total(input logic [TOT_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0FFF_FFFF) ? 28'hFFF_FFFF : w[27:0];
   endfunction

endpackage

### src/sblc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_cell: one cache entry
// Holds key, tag, stamp, size, valid bit and recency rank, selects itself
// by the command's mode and passes the selected entry down the chain.
// ----------------------------------------------------------------------------
module sblc_cell (
   input  logic                clock,
   input  logic                reset,
   input  sblc_pkg::cmd_type   cmd,
   input  sblc_pkg::chain_type chain_in,
   output sblc_pkg::chain_type chain_out,
   output sblc_pkg::status_type stat
);

   logic [31:0]                 key_ff;
   logic [31:0]                 tag_ff;
   logic [31:0]                 stamp_ff;
   logic [23:0]                 bytes_ff;
   logic                        valid_ff;
   logic [sblc_pkg::RANK_W-1:0] rank_ff;
   logic                        sel;
   logic                        is_free;

   assign is_free     = !valid_ff && !chain_in.free_seen;
   assign stat.match  = valid_ff && (key_ff == cmd.key);
   assign stat.oldest = valid_ff && (rank_ff == '0);

   always_comb begin
      case (cmd.mode)
         sblc_pkg::SEL_MATCH:  sel = stat.match;
         sblc_pkg::SEL_OLDEST: sel = stat.oldest;
         sblc_pkg::SEL_FREE:   sel = is_free;
         default:              sel = 1'b0;
      endcase
   end

   always_comb begin
      chain_out           = chain_in;
      chain_out.free_seen = chain_in.free_seen || !valid_ff;
      if (sel) begin
         chain_out.found = 1'b1;
         chain_out.rank  = chain_in.rank | rank_ff;
         chain_out.bytes = chain_in.bytes | bytes_ff;
         chain_out.tag   = chain_in.tag | tag_ff;
         chain_out.stamp = chain_in.stamp | stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         case (cmd.action)
            sblc_pkg::ACT_NEWEST: begin
               if (sel) begin
                  rank_ff <= cmd.new_rank;
               end else if (valid_ff && rank_ff > cmd.ref_rank) begin
                  rank_ff <= rank_ff - 1'b1;
               end
            end
            sblc_pkg::ACT_DROP: begin
               if (sel) begin
                  valid_ff <= 1'b0;
                  rank_ff  <= '0;
               end else if (valid_ff && rank_ff > cmd.ref_rank) begin
                  rank_ff <= rank_ff - 1'b1;
               end
            end
            sblc_pkg::ACT_PLACE: begin
               if (sel) begin
                  valid_ff <= 1'b1;
                  rank_ff  <= cmd.new_rank;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel && cmd.write) begin
         key_ff   <= cmd.key;
         tag_ff   <= cmd.tag;
         stamp_ff <= cmd.stamp;
         bytes_ff <= cmd.bytes;
      end
   end

endmodule

### src/size_budget_lru_cache.sv
`timescale 1ns / 1ps
// Request path: fetch, remove and insert of a present key pass the apply state; an
// insert of a new key then passes the place state, after an evict state when the
// table is full; trimming passes the trim state, which it holds for each eviction.
// Throughput: one request at a time. A new request is taken while the previous
// response waits.
// Reset (synchronous): all entries invalid, total and count zero, budget 8196.
// ----------------------------------------------------------------------------
// size_budget_lru_cache: keyed LRU cache with a byte budget
// A row of entry cells searched in parallel; a sequencer applies fetch,
// insert, remove and trim and evicts least-recent entries over the budget.
// ----------------------------------------------------------------------------
module size_budget_lru_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_key,
   input  logic [31:0] req_data_tag,
   input  logic [31:0] req_stamp,
   input  logic [23:0] req_entry_size,
   input  logic        req_trim_enable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [31:0] rsp_found_tag,
   output logic [31:0] rsp_found_stamp,
   output logic        rsp_had_effect,
   output logic [4:0]  rsp_evicted_count,
   output logic [27:0] rsp_total_size,
   output logic [4:0]  rsp_entry_count,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int N = sblc_pkg::ENTRIES;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_EVICT_FULL,
      ST_PLACE,
      ST_TRIM,
      ST_FINISH
   } state_type;

   state_type                  state_ff;
   logic [31:0]                max_size_ff;
   logic [1:0]                 op_ff;
   logic [31:0]                key_ff;
   logic [31:0]                tag_ff;
   logic [31:0]                stamp_ff;
   logic [23:0]                size_ff;
   logic                       trim_en_ff;
   logic [sblc_pkg::TOT_W-1:0] total_ff;
   logic [sblc_pkg::CNT_W-1:0] count_ff;
   logic [sblc_pkg::CNT_W-1:0] evicted_ff;
   logic                       hit_ff;
   logic                       effect_ff;
   logic [31:0]                ftag_ff;
   logic [31:0]                fstamp_ff;
   logic                       rsp_valid_ff;

   sblc_pkg::cmd_type          cmd;
   sblc_pkg::chain_type        chain [0:N];
   sblc_pkg::status_type       stat [0:N-1];
   logic [N-1:0]               match_vec;
   logic [N-1:0]               oldest_vec;
   sblc_pkg::chain_type        sel_info;
   logic                       over_budget;
   logic [sblc_pkg::TOT_W-1:0] sel_bytes;
   logic [sblc_pkg::TOT_W-1:0] new_bytes;

   assign chain[0] = '0;
   assign sel_info = chain[N];

   for (genvar i = 0; i < N; i++) begin : g_cell
      sblc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .stat      (stat[i])
      );
      assign match_vec[i]  = stat[i].match;
      assign oldest_vec[i] = stat[i].oldest;
   end

   assign sel_bytes = sblc_pkg::TOT_W'(sel_info.bytes);
   assign new_bytes = sblc_pkg::TOT_W'(size_ff);
   assign over_budget = (max_size_ff != '0) && (count_ff > sblc_pkg::CNT_W'(1))
      && (sblc_pkg::CMP_W'(total_ff) > sblc_pkg::CMP_W'(max_size_ff));

   always_comb begin
      cmd          = '0;
      cmd.mode     = sblc_pkg::SEL_NONE;
      cmd.action   = sblc_pkg::ACT_NONE;
      cmd.key      = key_ff;
      cmd.tag      = tag_ff;
      cmd.stamp    = stamp_ff;
      cmd.bytes    = size_ff;
      cmd.ref_rank = sel_info.rank;
      cmd.new_rank = sblc_pkg::RANK_W'(count_ff - 1'b1);
      case (state_ff)
         ST_APPLY: begin
            cmd.mode = sblc_pkg::SEL_MATCH;
            if (sel_info.found) begin
               if (op_ff == sblc_pkg::OP_FETCH) begin
                  cmd.action = sblc_pkg::ACT_NEWEST;
               end else if (op_ff == sblc_pkg::OP_INSERT) begin
                  cmd.action = sblc_pkg::ACT_NEWEST;
                  cmd.write  = 1'b1;
               end else if (op_ff == sblc_pkg::OP_REMOVE) begin
                  cmd.action = sblc_pkg::ACT_DROP;
               end
            end
         end
         ST_EVICT_FULL: begin
            cmd.mode   = sblc_pkg::SEL_OLDEST;
            cmd.action = sblc_pkg::ACT_DROP;
         end
         ST_PLACE: begin
            cmd.mode     = sblc_pkg::SEL_FREE;
            cmd.action   = sblc_pkg::ACT_PLACE;
            cmd.write    = 1'b1;
            cmd.new_rank = sblc_pkg::RANK_W'(count_ff);
         end
         ST_TRIM: begin
            cmd.mode = sblc_pkg::SEL_OLDEST;
            if (over_budget) begin
               cmd.action = sblc_pkg::ACT_DROP;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= sblc_pkg::MAX_SIZE_RESET;
      end else if (csr_wr_en) begin
         max_size_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the finish state the response register is handled below.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff      <= req_op;
                  key_ff     <= req_key;
                  tag_ff     <= req_data_tag;
                  stamp_ff   <= req_stamp;
                  size_ff    <= req_entry_size;
                  trim_en_ff <= req_trim_enable;
                  evicted_ff <= '0;
                  hit_ff     <= 1'b0;
                  effect_ff  <= 1'b0;
                  ftag_ff    <= '0;
                  fstamp_ff  <= '0;
                  state_ff   <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               hit_ff <= (op_ff != sblc_pkg::OP_TRIM) && sel_info.found;
               if (op_ff == sblc_pkg::OP_TRIM) begin
                  state_ff <= ST_TRIM;
               end else if (op_ff == sblc_pkg::OP_FETCH) begin
                  state_ff <= ST_FINISH;
                  if (sel_info.found) begin
                     ftag_ff   <= sel_info.tag;
                     fstamp_ff <= sel_info.stamp;
                  end
               end else if (op_ff == sblc_pkg::OP_INSERT) begin
                  effect_ff <= 1'b1;
                  if (sel_info.found) begin
                     total_ff <= total_ff - sel_bytes + new_bytes;
                     state_ff <= trim_en_ff ? ST_TRIM : ST_FINISH;
                  end else if (count_ff >= sblc_pkg::CNT_W'(N)) begin
                     state_ff <= ST_EVICT_FULL;
                  end else begin
                     state_ff <= ST_PLACE;
                  end
               end else if (sel_info.found) begin
                  effect_ff <= 1'b1;
                  total_ff  <= total_ff - sel_bytes;
                  count_ff  <= count_ff - 1'b1;
                  state_ff  <= trim_en_ff ? ST_TRIM : ST_FINISH;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_EVICT_FULL: begin
               total_ff   <= total_ff - sel_bytes;
               count_ff   <= count_ff - 1'b1;
               evicted_ff <= evicted_ff + 1'b1;
               state_ff   <= ST_PLACE;
            end
            ST_PLACE: begin
               total_ff <= total_ff + new_bytes;
               count_ff <= count_ff + 1'b1;
               state_ff <= trim_en_ff ? ST_TRIM : ST_FINISH;
            end
            ST_TRIM: begin
               if (over_budget) begin
                  total_ff   <= total_ff - sel_bytes;
                  count_ff   <= count_ff - 1'b1;
                  evicted_ff <= evicted_ff + 1'b1;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_hit           <= hit_ff;
                  rsp_found_tag     <= ftag_ff;
                  rsp_found_stamp   <= fstamp_ff;
                  rsp_had_effect    <= effect_ff;
                  rsp_evicted_count <= sblc_pkg::sat_count(evicted_ff);
                  rsp_total_size    <= sblc_pkg::sat_total(total_ff);
                  rsp_entry_count   <= sblc_pkg::sat_count(count_ff);
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // Keys are unique among valid entries.
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec)) else $error("key present in more than one entry");

   // Exactly one least-recent entry whenever the table is not empty.
   a_oldest_unique: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> $onehot(oldest_vec))
      else $error("least-recent entry not unique");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sblc_pkg::CNT_W'(N)) else $error("entry count above capacity");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (total_ff == '0)) else $error("empty table with bytes");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for size_budget_lru_cache
// Drives fetch, insert, remove and trim requests with random idling on both
// channels, predicts each response from a behavioral LRU cache with a byte
// budget, and compares every response field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] tag;
      logic [31:0] stamp;
      logic [23:0] size;
      logic        trim_en;
   } request_type;

   typedef struct {
      logic        hit;
      logic [31:0] tag;
      logic [31:0] stamp;
      logic        effect;
      logic [4:0]  evicted;
      logic [27:0] total;
      logic [4:0]  count;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = sblc_pkg::OP_FETCH;
   logic [31:0] req_key = '0;
   logic [31:0] req_data_tag = '0;
   logic [31:0] req_stamp = '0;
   logic [23:0] req_entry_size = '0;
   logic        req_trim_enable = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [31:0] rsp_found_tag;
   logic [31:0] rsp_found_stamp;
   logic        rsp_had_effect;
   logic [4:0]  rsp_evicted_count;
   logic [27:0] rsp_total_size;
   logic [4:0]  rsp_entry_count;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   size_budget_lru_cache uut (.*);

   always #1 clock = ~clock;

   // Behavioral copy of the cache.
   logic [31:0] cache_key [sblc_pkg::ENTRIES];
   logic [31:0] cache_tag [sblc_pkg::ENTRIES];
   logic [31:0] cache_stamp [sblc_pkg::ENTRIES];
   logic [23:0] cache_bytes [sblc_pkg::ENTRIES];
   bit          cache_valid [sblc_pkg::ENTRIES];
   int unsigned cache_rank [sblc_pkg::ENTRIES];
   int unsigned cache_total;
   int unsigned cache_count;
   logic [31:0] byte_budget;

   response_type expected_responses[$];
   logic [31:0] key_pool [24];
   int          idle_pct = 32;
   int          hold_left = 0;
   int          stall_cycles = 0;
   bit          failed = 0;

   function automatic int lookup_key(logic [31:0] k);
      for (int i = 0; i < sblc_pkg::ENTRIES; i++)
         if (cache_valid[i] && cache_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int lookup_oldest();
      for (int i = 0; i < sblc_pkg::ENTRIES; i++)
         if (cache_valid[i] && cache_rank[i] == 0) return i;
      return -1;
   endfunction

   function automatic int lookup_free();
      for (int i = 0; i < sblc_pkg::ENTRIES; i++)
         if (!cache_valid[i]) return i;
      return -1;
   endfunction

   function automatic void close_gap(int unsigned r);
      for (int i = 0; i < sblc_pkg::ENTRIES; i++)
         if (cache_valid[i] && cache_rank[i] > r) cache_rank[i]--;
   endfunction

   function automatic void drop_entry(int s);
      cache_valid[s] = 0;
      close_gap(cache_rank[s]);
      cache_rank[s] = 0;
      cache_total -= cache_bytes[s];
      cache_count--;
   endfunction

   function automatic void promote(int s);
      cache_valid[s] = 0;
      close_gap(cache_rank[s]);
      cache_valid[s] = 1;
      cache_rank[s] = cache_count - 1;
   endfunction

   function automatic int unsigned evict_over_budget();
      int unsigned n;
      int s;
      n = 0;
      if (byte_budget == 0) return 0;
      while (cache_count > 1 && cache_total > byte_budget) begin
         s = lookup_oldest();
         if (s < 0) break;
         drop_entry(s);
         n++;
      end
      return n;
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type p;
      int          s;
      int          o;
      int unsigned ev;
      p = '{default: '0};
      ev = 0;
      s = (r.op == sblc_pkg::OP_TRIM) ? -1 : lookup_key(r.key);
      p.hit = (s >= 0);
      case (r.op)
         sblc_pkg::OP_FETCH: begin
            if (s >= 0) begin
               p.tag = cache_tag[s];
               p.stamp = cache_stamp[s];
               promote(s);
            end
         end
         sblc_pkg::OP_INSERT: begin
            p.effect = 1'b1;
            if (s >= 0) begin
               cache_total -= cache_bytes[s];
               promote(s);
            end else begin
               if (cache_count >= sblc_pkg::ENTRIES) begin
                  o = lookup_oldest();
                  if (o >= 0) begin
                     drop_entry(o);
                     ev++;
                  end
               end
               s = lookup_free();
               if (s >= 0) begin
                  cache_valid[s] = 1;
                  cache_rank[s] = cache_count;
                  cache_count++;
               end
            end
            if (s >= 0) begin
               cache_key[s] = r.key;
               cache_tag[s] = r.tag;
               cache_stamp[s] = r.stamp;
               cache_bytes[s] = r.size;
               cache_total += r.size;
            end
            if (r.trim_en) ev += evict_over_budget();
         end
         sblc_pkg::OP_REMOVE: begin
            if (s >= 0) begin
               p.effect = 1'b1;
               drop_entry(s);
               if (r.trim_en) ev += evict_over_budget();
            end
         end
         default: ev += evict_over_budget();
      endcase
      p.evicted = (ev > 31) ? 5'd31 : ev[4:0];
      p.total = (cache_total > 32'h0FFF_FFFF) ? 28'hFFF_FFFF : cache_total[27:0];
      p.count = (cache_count > 31) ? 5'd31 : cache_count[4:0];
      return p;
   endfunction

   // Sends one request; valid stays high afterwards so back-to-back requests
   // never toggle it within one time step.
   task automatic send_request(request_type r);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_op <= r.op;
      req_key <= r.key;
      req_data_tag <= r.tag;
      req_stamp <= r.stamp;
      req_entry_size <= r.size;
      req_trim_enable <= r.trim_en;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_responses = {expected_responses, apply_request(r)};
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_budget(logic [31:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      byte_budget = v;
   endtask

   function automatic request_type make_request(logic [1:0] op, logic [31:0] k,
                                                logic [23:0] sz, logic te);
      request_type r;
      r.op = op;
      r.key = k;
      r.tag = $urandom;
      r.stamp = $urandom;
      r.size = sz;
      r.trim_en = te;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int       pick;
      pick = $urandom_range(99);
      r = make_request(pick < 40 ? sblc_pkg::OP_INSERT : pick < 70 ? sblc_pkg::OP_FETCH :
                       pick < 90 ? sblc_pkg::OP_REMOVE : sblc_pkg::OP_TRIM,
                       ($urandom_range(9) == 0) ? $urandom
                                                : key_pool[$urandom_range(23)],
                       ($urandom_range(6) == 0) ? 24'($urandom)
                                                : 24'($urandom_range(3000)),
                       $urandom_range(3) != 0);
      return r;
   endfunction

   task automatic test_directed();
      send_request(make_request(sblc_pkg::OP_FETCH, 32'h0, 24'd5, 1'b1));
      send_request(make_request(sblc_pkg::OP_REMOVE, 32'hFFFF_FFFF, 24'd5, 1'b1));
      send_request(make_request(sblc_pkg::OP_TRIM, 32'h0, 24'd0, 1'b0));
      send_request(make_request(sblc_pkg::OP_INSERT, 32'h0, 24'd0, 1'b1));
      send_request(make_request(sblc_pkg::OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0));
      send_request('{sblc_pkg::OP_INSERT, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     24'd100, 1'b0});
      send_request(make_request(sblc_pkg::OP_FETCH, 32'h1234_5678, 24'd0, 1'b0));
      send_request(make_request(sblc_pkg::OP_FETCH, 32'h0, 24'd0, 1'b0));
      // Replace shrinks the big entry; then grow it back and trim explicitly.
      send_request(make_request(sblc_pkg::OP_INSERT, 32'hFFFF_FFFF, 24'd10, 1'b1));
      send_request(make_request(sblc_pkg::OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0));
      send_request(make_request(sblc_pkg::OP_TRIM, 32'h0, 24'd0, 1'b1));
      // The single remaining entry survives even over budget.
      send_request(make_request(sblc_pkg::OP_INSERT, 32'h0, 24'hFF_FFFF, 1'b1));
      send_request(make_request(sblc_pkg::OP_REMOVE, 32'hFFFF_FFFF, 24'd0, 1'b1));
      // Overfill the table so that new keys beyond its capacity displace the oldest entry.
      for (int i = 0; i < 18; i++)
         send_request(make_request(sblc_pkg::OP_INSERT, key_pool[i], 24'd7, 1'b1));
   endtask

   task automatic test_budget_phase(logic [31:0] budget, int n, int idle);
      write_budget(budget);
      idle_pct = idle;
      for (int i = 0; i < n; i++) send_request(random_request());
      idle_pct = 32;
   endtask

   task automatic test_backpressure();
      write_budget(32'd20000);
      hold_left = 120;
      for (int i = 0; i < 12; i++) send_request(random_request());
      wait_drained();
      for (int i = 0; i < 20; i++) send_request(random_request());
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $display("%0t: %s expected %h, actual %h", $time, name, exp, act);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual total %h",
                     $time, rsp_total_size);
            failed = 1;
         end else begin
            e = expected_responses.pop_front();
            check_field("hit", e.hit, rsp_hit);
            check_field("found_tag", e.tag, rsp_found_tag);
            check_field("found_stamp", e.stamp, rsp_found_stamp);
            check_field("had_effect", e.effect, rsp_had_effect);
            check_field("evicted_count", e.evicted, rsp_evicted_count);
            check_field("total_size", e.total, rsp_total_size);
            check_field("entry_count", e.count, rsp_entry_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
      for (int i = 0; i < sblc_pkg::ENTRIES; i++) begin
         cache_valid[i] = 0;
         cache_rank[i] = 0;
         cache_key[i] = '0;
         cache_tag[i] = '0;
         cache_stamp[i] = '0;
         cache_bytes[i] = '0;
      end
      cache_total = 0;
      cache_count = 0;
      byte_budget = sblc_pkg::MAX_SIZE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_budget_phase(32'd0, 150, 32);
      test_budget_phase(32'hFFFF_FFFF, 120, 32);
      test_budget_phase(32'd1, 120, 0);
      test_budget_phase($urandom_range(2000, 60000), 150, 32);
      test_backpressure();
      test_budget_phase(sblc_pkg::MAX_SIZE_RESET, 250, 32);
      wait_drained();
      if (!failed)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
src/sblc_pkg.sv
src/sblc_cell.sv
src/size_budget_lru_cache.sv
verif/testbench.sv
